// ===== hw/rtl/met_pkg.sv =====
// Shared constants and controller/datapath interface types for the
// Mandelbrot escape-time block. No dependencies.
`default_nettype none

package met_pkg;

    localparam int COORD_W    = 32;          // c and z components, signed Q4.28
    localparam int FRAC_BITS  = 28;
    localparam int COUNT_W    = 16;
    localparam int LIMIT_W    = 32;          // squared magnitude, unsigned Q8.24
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 2 * COORD_W;
    localparam int OUT_DATA_W = COUNT_W;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_LIMIT  = 1'd1;

    localparam logic [COUNT_W-1:0] MAX_ITER_RST  = 16'd256;
    localparam logic [LIMIT_W-1:0] ESC_LIMIT_RST = 32'h0400_0000;
    localparam logic [LIMIT_W-1:0] TWO_Q824      = 32'h0200_0000;

    typedef struct packed {
        logic load;     // capture c, clear z and the iteration count
        logic step;     // write back the updated z, advance the count
        logic finish;   // load the result word into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic at_max;   // iteration count reached max_iterations
        logic escaped;  // |z|^2 above the escape limit
        logic out_full; // output word still waiting and not taken now
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/met_ctrl.sv =====
// Sequencer for the escape-time loop: accepts a point, alternates the product
// and evaluate cycles, and issues the finish command. Depends on met_pkg.
`default_nettype none

module met_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire met_pkg::t_dp_sts i_sts,
    output met_pkg::t_dp_cmd      o_cmd
);
    import met_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_s_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_sts.at_max || i_sts.escaped) begin
                    // hold here while the previous result word is still pending
                    if (!i_sts.out_full) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/met_dpath.sv =====
// Datapath of the escape-time loop: configuration registers, z registers,
// registered squares and cross product, update and escape test, output word.
// Depends on met_pkg.
`default_nettype none

module met_dpath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [met_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [met_pkg::LIMIT_W-1:0]     i_cfg_wdata,
    input  wire logic signed [met_pkg::COORD_W-1:0] i_c_real,
    input  wire logic signed [met_pkg::COORD_W-1:0] i_c_imag,
    input  wire met_pkg::t_dp_cmd                i_cmd,
    output met_pkg::t_dp_sts                     o_sts,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [met_pkg::COUNT_W-1:0]          o_escape_count
);
    import met_pkg::*;

    localparam int MAG_W  = COORD_W - 1;       // |z| fits in 31 bits
    localparam int PROD_W = 2 * MAG_W;         // 62-bit exact product
    localparam int SQ_W   = PROD_W - FRAC_BITS; // 34-bit truncated product
    localparam int EXT_W  = SQ_W + 3;          // room for 2p + c with sign
    localparam int NORM_SHIFT = FRAC_BITS - 24;

    localparam logic signed [COORD_W-1:0] ZBOUND     = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] ZBOUND_NEG = -32'sh7FFF_FFFF;
    localparam logic signed [EXT_W-1:0]   ZB_EXT     = 37'sd2147483647;
    localparam logic signed [EXT_W-1:0]   ZB_EXT_NEG = -37'sd2147483647;

    function automatic logic signed [COORD_W-1:0] clamp_z(input logic signed [EXT_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > ZB_EXT) begin
            r = ZBOUND;
        end else if (v < ZB_EXT_NEG) begin
            r = ZBOUND_NEG;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    logic [COUNT_W-1:0]          r_max_iter;
    logic [LIMIT_W-1:0]          r_esc_limit;
    logic signed [COORD_W-1:0]   r_cr;
    logic signed [COORD_W-1:0]   r_ci;
    logic signed [COORD_W-1:0]   r_zr;
    logic signed [COORD_W-1:0]   r_zi;
    logic [COUNT_W-1:0]          r_iter;
    logic [SQ_W-1:0]             r_sq_r;
    logic [SQ_W-1:0]             r_sq_i;
    logic [SQ_W-1:0]             r_pm;
    logic                        r_psign;
    logic                        r_out_valid;
    logic [COUNT_W-1:0]          r_out_count;

    logic [COORD_W-1:0]          w_zr_neg;
    logic [COORD_W-1:0]          w_zi_neg;
    logic [MAG_W-1:0]            w_ar;
    logic [MAG_W-1:0]            w_ai;
    logic [PROD_W-1:0]           w_prr;
    logic [PROD_W-1:0]           w_pii;
    logic [PROD_W-1:0]           w_pri;
    logic [SQ_W:0]               w_mag_sum;
    logic [LIMIT_W-1:0]          w_mag;
    logic signed [EXT_W-1:0]     w_cr_ext;
    logic signed [EXT_W-1:0]     w_ci_ext;
    logic signed [EXT_W-1:0]     w_pm_ext;
    logic signed [EXT_W-1:0]     w_p;
    logic signed [EXT_W-1:0]     w_nr;
    logic signed [EXT_W-1:0]     w_ni;
    logic signed [COORD_W-1:0]   n_zr;
    logic signed [COORD_W-1:0]   n_zi;
    logic [COUNT_W-1:0]          n_out_count;

    // magnitudes of z; the clamp keeps them below 2^31
    assign w_zr_neg = -r_zr;
    assign w_zi_neg = -r_zi;
    assign w_ar = r_zr[COORD_W-1] ? w_zr_neg[MAG_W-1:0] : r_zr[MAG_W-1:0];
    assign w_ai = r_zi[COORD_W-1] ? w_zi_neg[MAG_W-1:0] : r_zi[MAG_W-1:0];

    assign w_prr = w_ar * w_ar;
    assign w_pii = w_ai * w_ai;
    assign w_pri = w_ar * w_ai;

    // |z|^2 in Q8.24: the sum stays below 2^35, so no saturation is reachable
    assign w_mag_sum = {1'b0, r_sq_r} + {1'b0, r_sq_i};
    assign w_mag     = {1'b0, w_mag_sum[SQ_W:NORM_SHIFT]};

    assign w_cr_ext = {{(EXT_W-COORD_W){r_cr[COORD_W-1]}}, r_cr};
    assign w_ci_ext = {{(EXT_W-COORD_W){r_ci[COORD_W-1]}}, r_ci};
    assign w_pm_ext = {3'b000, r_pm};
    assign w_p      = r_psign ? -w_pm_ext : w_pm_ext;

    assign w_nr = $signed({3'b000, r_sq_r}) - $signed({3'b000, r_sq_i}) + w_cr_ext;
    assign w_ni = {w_p[EXT_W-2:0], 1'b0} + w_ci_ext;
    assign n_zr = clamp_z(w_nr);
    assign n_zi = clamp_z(w_ni);

    assign o_sts.at_max   = (r_iter == r_max_iter);
    assign o_sts.escaped  = (w_mag > r_esc_limit);
    assign o_sts.out_full = r_out_valid && !i_m_tready;

    always_comb begin
        if (r_iter == r_max_iter) begin
            n_out_count = (w_mag < TWO_Q824) ? '0 : r_max_iter;
        end else begin
            n_out_count = r_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter  <= MAX_ITER_RST;
            r_esc_limit <= ESC_LIMIT_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MAX_ITER:  r_max_iter  <= i_cfg_wdata[COUNT_W-1:0];
                    REG_ESC_LIMIT: r_esc_limit <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // products of the current z, taken every cycle
        r_sq_r  <= w_prr[PROD_W-1:FRAC_BITS];
        r_sq_i  <= w_pii[PROD_W-1:FRAC_BITS];
        r_pm    <= w_pri[PROD_W-1:FRAC_BITS];
        r_psign <= r_zr[COORD_W-1] ^ r_zi[COORD_W-1];
        if (i_cmd.load) begin
            // the one out-of-range code is the most negative value
            r_cr   <= (i_c_real < ZBOUND_NEG) ? ZBOUND_NEG : i_c_real;
            r_ci   <= (i_c_imag < ZBOUND_NEG) ? ZBOUND_NEG : i_c_imag;
            r_zr   <= '0;
            r_zi   <= '0;
            r_iter <= '0;
        end else if (i_cmd.step) begin
            r_zr   <= n_zr;
            r_zi   <= n_zi;
            r_iter <= r_iter + 1'b1;
        end
        if (i_cmd.finish) begin
            r_out_count <= n_out_count;
        end
    end

    assign o_m_tvalid     = r_out_valid;
    assign o_escape_count = r_out_count;

endmodule

`default_nettype wire

// ===== hw/rtl/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time unit. An accepted word is worked through a loop of registered
// products and update through one z register pair, with at most max_iterations z
// updates before the exit; no new word is taken until its result word is written,
// and a result word still pending holds the unit.
// Reset (synchronous, active low): max_iterations 256, escape_limit 4.0,
// sequencer idle, output word empty.
`default_nettype none

module mandelbrot_escape_time (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [met_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [met_pkg::LIMIT_W-1:0]        i_cfg_wdata,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [met_pkg::IN_DATA_W-1:0]      i_s_tdata,  // c_real[31:0], c_imag[63:32]
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    output logic [met_pkg::OUT_DATA_W-1:0]          o_m_tdata   // escape_count[15:0]
);
    import met_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    met_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    met_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_c_real       ($signed(i_s_tdata[COORD_W-1:0])),
        .i_c_imag       ($signed(i_s_tdata[IN_DATA_W-1:COORD_W])),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_escape_count (o_m_tdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/met_checker.sv =====
// Port-level checks for mandelbrot_escape_time, attached by bind.
// Depends on met_pkg and the top level's port list.
`default_nettype none

module met_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_tvalid,
    input wire logic                          o_s_tready,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [met_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import met_pkg::*;

    // one point in flight: ready drops right after a word is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready stayed high after an accepted word");

    // no result word before the first evaluate cycle of a fresh point
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !o_m_tvalid) |=> !o_m_tvalid)
        else $error("result word appeared one cycle after accept");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result word changed or dropped");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        (!i_rst_n) |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind mandelbrot_escape_time met_checker u_met_checker (.*);

`default_nettype wire

// ===== tb/tb_mandelbrot_escape_time.sv =====
// Self-checking testbench for the Mandelbrot escape-time block: drives points of the
// complex plane over the input stream and checks every escape count against a predictor.
// Depends on met_pkg and the mandelbrot_escape_time RTL only.
`default_nettype none

module tb_mandelbrot_escape_time;
    timeunit 1ns;
    timeprecision 1ps;

    import met_pkg::*;

    localparam int RANDOM_POINTS = 650;
    localparam int LONG_HOLD     = 3000;

    // Q4.28 coordinates and Q8.24 limits used by the directed part
    localparam logic [COORD_W-1:0] C_ZERO    = 32'h0000_0000;
    localparam logic [COORD_W-1:0] C_ONE     = 32'h1000_0000;
    localparam logic [COORD_W-1:0] C_NEG_ONE = 32'hF000_0000;
    localparam logic [COORD_W-1:0] C_TWO     = 32'h2000_0000;
    localparam logic [COORD_W-1:0] C_NEG_TWO = 32'hE000_0000;
    localparam logic [COORD_W-1:0] C_ONE_HLF = 32'h1800_0000;
    localparam logic [COORD_W-1:0] C_QUARTER = 32'h0400_0000;
    localparam logic [COORD_W-1:0] C_MAX_POS = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] C_MAX_NEG = 32'h8000_0000;
    localparam logic [LIMIT_W-1:0] L_ONE     = 32'h0100_0000;

    class escape_scoreboard;
        logic [COUNT_W-1:0] max_iter;
        logic [LIMIT_W-1:0] esc_limit;
        logic [COUNT_W-1:0] count_q[$];
        int n_points;
        int n_counts;
        int n_errors;

        function new();
            max_iter  = MAX_ITER_RST;
            esc_limit = ESC_LIMIT_RST;
            n_points  = 0;
            n_counts  = 0;
            n_errors  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
            case (idx)
                REG_MAX_ITER:  max_iter = val[COUNT_W-1:0];
                REG_ESC_LIMIT: esc_limit = val;
                default: ;
            endcase
        endfunction

        function longint clamp_z(longint v);
            longint zb;
            zb = (longint'(1) <<< (FRAC_BITS + 3)) - 1;
            if (v > zb) return zb;
            if (v < -zb) return -zb;
            return v;
        endfunction

        // z stays within +-8.0, so the full product fits in 64 bits; round toward zero
        function longint mul_q(longint a, longint b);
            longint p;
            p = a * b;
            return (p < 0) ? -((-p) >>> FRAC_BITS) : (p >>> FRAC_BITS);
        endfunction

        function longint mag_q824(longint zr, longint zi);
            longint s;
            s = mul_q(zr, zr) + mul_q(zi, zi);
            if (s < 0) s = 0;
            s = s >>> (FRAC_BITS - 24);
            if (s > longint'(64'hFFFF_FFFF)) s = longint'(64'hFFFF_FFFF);
            return s;
        endfunction

        function logic [COUNT_W-1:0] escape_count(logic [COORD_W-1:0] re_raw,
                                                  logic [COORD_W-1:0] im_raw);
            longint cr, ci, zr, zi, nr, ni, p, mag, lim, two;
            logic [COUNT_W-1:0] count;
            bit escaped;
            int j;
            cr  = clamp_z(longint'($signed(re_raw)) <<< (FRAC_BITS - 28));
            ci  = clamp_z(longint'($signed(im_raw)) <<< (FRAC_BITS - 28));
            zr  = 0;
            zi  = 0;
            mag = 0;
            lim = esc_limit;
            two = TWO_Q824;
            count = max_iter;
            escaped = 0;
            for (j = 0; j < int'(max_iter); j++) begin
                // escape test comes before each update, strictly greater
                if (mag > lim) begin
                    count = j[COUNT_W-1:0];
                    escaped = 1;
                    break;
                end
                nr = clamp_z(mul_q(zr, zr) - mul_q(zi, zi) + cr);
                p  = mul_q(zr, zi);
                ni = clamp_z(p + p + ci);
                zr = nr;
                zi = ni;
                mag = mag_q824(zr, zi);
            end
            if (!escaped) count = (mag < two) ? '0 : max_iter;
            return count;
        endfunction

        function void note_point(logic [COORD_W-1:0] re_raw, logic [COORD_W-1:0] im_raw);
            count_q = {count_q, escape_count(re_raw, im_raw)};
            n_points++;
        endfunction

        function void check_count(logic [COUNT_W-1:0] got);
            logic [COUNT_W-1:0] want;
            n_counts++;
            if (count_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected word: count %0d with no point pending", got);
                return;
            end
            want = count_q.pop_front();
            if (got !== want) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("escape_count mismatch on word %0d: expected %0d, got %0d",
                             n_counts, want, got);
            end
        endfunction

        function int pending();
            return count_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [LIMIT_W-1:0]    i_cfg_wdata;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;   // c_real[31:0], c_imag[63:32]
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // escape_count[15:0]

    escape_scoreboard sb;
    bit no_idle;
    int n_settings;

    mandelbrot_escape_time u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(40_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    // all drive tasks start and end at a falling edge
    task automatic send_point(input logic [COORD_W-1:0] re, input logic [COORD_W-1:0] im);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {im, re};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        sb.note_point(re, im);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        i_s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic set_config(input logic [COUNT_W-1:0] iters, input logic [LIMIT_W-1:0] lim);
        wait_drain();
        write_reg(REG_MAX_ITER, {{(LIMIT_W-COUNT_W){1'b0}}, iters});
        write_reg(REG_ESC_LIMIT, lim);
        n_settings++;
    endtask

    function logic [COORD_W-1:0] rand_coord(int lo, int hi);
        return COORD_W'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    // mostly points near the set, some anywhere, some at the extremes
    task automatic send_random_point();
        logic [COORD_W-1:0] re, im;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            re = rand_coord(-603979776, 201326592);   // -2.25 .. 0.75
            im = rand_coord(-402653184, 402653184);   // -1.5 .. 1.5
        end else if (r < 88) begin
            re = $urandom;
            im = $urandom;
        end else begin
            case ($urandom_range(0, 5))
                0: re = C_MAX_POS;
                1: re = C_MAX_NEG;
                2: re = C_NEG_TWO;
                3: re = C_ZERO;
                4: re = rand_coord(-4096, 4096);
                default: re = $urandom;
            endcase
            im = ($urandom_range(0, 1) == 1) ? C_MAX_NEG : rand_coord(-4096, 4096);
        end
        send_point(re, im);
    endtask

    // receiver: random gaps, and one long hold so the block backs up into its input
    initial begin
        int stall_left;
        bit held;
        stall_left = 0;
        held = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && sb.n_counts >= 100) begin
                held = 1;
                stall_left = LONG_HOLD;
            end
            if (stall_left == 0) stall_left = pick_gap();
            if (stall_left > 0) begin
                i_m_tready = 1'b0;
                stall_left--;
            end else begin
                i_m_tready = 1'b1;
            end
            @(posedge i_clk);
            if (o_m_tvalid === 1'b1 && i_m_tready) sb.check_count(o_m_tdata);
        end
    end

    initial begin
        int n_random;
        int batch;
        int r;
        logic [COUNT_W-1:0] iters;
        logic [LIMIT_W-1:0] lim;
        sb = new();
        no_idle     = 0;
        n_settings  = 1;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset settings: 256 iterations, limit 4.0
        send_point(C_ZERO, C_ZERO);
        send_point(C_MAX_POS, C_MAX_POS);
        send_point(C_MAX_NEG, C_MAX_NEG);
        send_point(C_NEG_TWO, C_ZERO);        // settles at |z|^2 equal to the limit
        send_point(C_QUARTER, C_ZERO);
        send_point(C_NEG_ONE, C_ZERO);
        send_point(C_ZERO, C_ONE);
        send_point(C_MAX_POS, C_ZERO);
        send_point(C_ZERO, C_MAX_NEG);
        send_point(32'h0000_0001, 32'hFFFF_FFFF);
        send_point(32'h04CC_CCCD, 32'h0800_0000);

        // no iterations at all
        set_config('0, ESC_LIMIT_RST);
        send_point(C_TWO, C_TWO);
        send_point(C_ZERO, C_ZERO);

        // one iteration against a zero limit: ends by running out
        set_config(16'd1, '0);
        send_point(C_ONE, C_ZERO);
        send_point(C_ONE_HLF, C_ZERO);

        // |z|^2 equal to the limit does not escape, one below it does
        set_config(16'd10, L_ONE);
        send_point(C_ONE, C_ZERO);
        set_config(16'd10, L_ONE - 1);
        send_point(C_ONE, C_ZERO);

        // limit out of reach: always runs out
        set_config(16'd50, 32'hFFFF_FFFF);
        send_point(C_TWO, C_TWO);
        send_point(C_ZERO, C_ZERO);
        send_point(C_NEG_ONE, C_ZERO);

        // largest iteration count, only for a couple of points
        set_config(16'hFFFF, ESC_LIMIT_RST);
        send_point(C_ONE_HLF, C_ONE_HLF);
        send_point(C_ZERO, C_ZERO);

        n_random = 0;
        while (n_random < RANDOM_POINTS) begin
            r = $urandom_range(0, 99);
            if (r < 5) iters = '0;
            else if (r < 20) iters = COUNT_W'($urandom_range(1, 4));
            else if (r < 70) iters = COUNT_W'($urandom_range(5, 64));
            else if (r < 95) iters = COUNT_W'($urandom_range(65, 300));
            else iters = MAX_ITER_RST;
            r = $urandom_range(0, 99);
            if (r < 50) lim = ESC_LIMIT_RST;
            else if (r < 70) lim = $urandom;
            else if (r < 80) lim = '0;
            else if (r < 90) lim = 32'hFFFF_FFFF;
            else lim = $urandom_range(0, 32'h0400_0000);
            set_config(iters, lim);
            no_idle = ($urandom_range(0, 3) == 0);
            batch = $urandom_range(20, 60);
            repeat (batch) begin
                send_random_point();
                n_random++;
            end
        end

        no_idle = 0;
        wait_drain();
        repeat (50) @(negedge i_clk);

        $display("Checked %0d escape counts for %0d points over %0d register settings,",
                 sb.n_counts, sb.n_points, n_settings);
        $display("iteration limits from 0 to 65535, zero and unreachable escape limits.");
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d counts outstanding", sb.n_errors, sb.pending());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
